/* hdl/mi3_pkg.sv */
// ----------------------------------------------------------------------------
// mi3_pkg
// Shared types and constants for the 3x3 fixed-point matrix inverse.
// ----------------------------------------------------------------------------
package mi3_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int FIELD_W        = 32;

    typedef struct packed {
        logic signed [FIELD_W-1:0] m00;
        logic signed [FIELD_W-1:0] m01;
        logic signed [FIELD_W-1:0] m02;
        logic signed [FIELD_W-1:0] m10;
        logic signed [FIELD_W-1:0] m11;
        logic signed [FIELD_W-1:0] m12;
        logic signed [FIELD_W-1:0] m20;
        logic signed [FIELD_W-1:0] m21;
        logic signed [FIELD_W-1:0] m22;
    } t_mat_in;

    typedef struct packed {
        logic signed [FIELD_W-1:0] inv00;
        logic signed [FIELD_W-1:0] inv01;
        logic signed [FIELD_W-1:0] inv02;
        logic signed [FIELD_W-1:0] inv10;
        logic signed [FIELD_W-1:0] inv11;
        logic signed [FIELD_W-1:0] inv12;
        logic signed [FIELD_W-1:0] inv20;
        logic signed [FIELD_W-1:0] inv21;
        logic signed [FIELD_W-1:0] inv22;
        logic                      singular;
    } t_mat_out;

    // Cofactor i = a[P]*a[Q] - a[R]*a[S], entries indexed row-major.
    localparam int CO_P [9] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
    localparam int CO_Q [9] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
    localparam int CO_R [9] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
    localparam int CO_S [9] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

endpackage

/* hdl/mi3_div.sv */
// ----------------------------------------------------------------------------
// mi3_div
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
// ----------------------------------------------------------------------------
module mi3_div
    import mi3_pkg::*;
#(
    parameter int NW  = 97,
    parameter int DMW = 99,
    parameter int QB  = 33
) (
    input  logic           i_clk,
    input  logic           i_en,
    input  logic [NW-1:0]  i_num,
    input  logic [DMW-1:0] i_den,
    output logic [QB-1:0]  o_q,
    output logic           o_ovf
);

    localparam int XW = ((NW > DMW + QB) ? NW : DMW + QB) + 1;

    logic [NW-1:0]  r_rem [QB+1];
    logic [DMW-1:0] r_den [QB+1];
    logic [QB-1:0]  r_q   [QB+1];
    logic           r_ovf [QB+1];

    // quotient at or above 2^QB saturates anyway
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= i_num;
            r_den[0] <= i_den;
            r_q[0]   <= '0;
            r_ovf[0] <= XW'(i_num) >= (XW'(i_den) << QB);
        end
    end

    for (genvar j = 1; j <= QB; j++) begin : g_stage
        localparam int B = QB - j;
        logic [XW-1:0] sh;
        logic          ge;
        assign sh = XW'(r_den[j-1]) << B;
        assign ge = XW'(r_rem[j-1]) >= sh;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j] <= ge ? NW'(XW'(r_rem[j-1]) - sh) : r_rem[j-1];
                r_den[j] <= r_den[j-1];
                r_q[j]   <= {r_q[j-1][QB-2:0], ge};
                r_ovf[j] <= r_ovf[j-1];
            end
        end
    end

    assign o_q   = r_q[QB];
    assign o_ovf = r_ovf[QB];

endmodule

/* hdl/matrix_inverse_3x3_top.sv */
// ----------------------------------------------------------------------------
// matrix_inverse_3x3_top
// 3x3 Q-format matrix inverse: exact adjugate and determinant, then a
// pipelined division per entry with truncation and saturation.
// ----------------------------------------------------------------------------
//  channel  | valid    | ready    | payload
//  ---------+----------+----------+-------------------------
//  matrix   | i_valid  | o_ready  | i_data  (t_mat_in)
//  inverse  | o_valid  | i_ready  | o_data  (t_mat_out)
//
// One matrix transfer per cycle while the output is not stalled; the pipeline
// is five arithmetic stages, DATA_WIDTH + 2 divider stages and an output
// register, its depth set by the bit-per-stage dividers.
// Reset clears every valid bit; the data path carries no reset.
// A stall on the output freezes the whole pipeline; nothing is dropped.
// ----------------------------------------------------------------------------
module matrix_inverse_3x3_top
    import mi3_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_mat_in  i_data,
    output logic     o_valid,
    input  logic     i_ready,
    output t_mat_out o_data
);

    localparam int W    = DATA_WIDTH;
    localparam int PW   = 2 * W;
    localparam int CW   = 2 * W + 1;
    localparam int DETW = 3 * W + 3;
    localparam int NW   = 2 * W + 1 + 2 * FRAC_BITS;
    localparam int QB   = W + 1;
    localparam int DD   = QB + 1;

    // pipeline advance: move when the output slot is free or being taken
    logic en;
    assign en      = !o_valid || i_ready;
    assign o_ready = en;

    logic [4:0] r_vld;
    logic       r_dvld [DD];

    // ---- stage 1: products --------------------------------------------------
    logic signed [W-1:0] a [9];
    assign a[0] = i_data.m00[W-1:0];
    assign a[1] = i_data.m01[W-1:0];
    assign a[2] = i_data.m02[W-1:0];
    assign a[3] = i_data.m10[W-1:0];
    assign a[4] = i_data.m11[W-1:0];
    assign a[5] = i_data.m12[W-1:0];
    assign a[6] = i_data.m20[W-1:0];
    assign a[7] = i_data.m21[W-1:0];
    assign a[8] = i_data.m22[W-1:0];

    logic signed [PW-1:0] r_pa [9];
    logic signed [PW-1:0] r_pb [9];
    logic signed [W-1:0]  r1_col [3];
    logic signed [W-1:0]  r2_col [3];

    for (genvar i = 0; i < 9; i++) begin : g_prod
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_pa[i] <= PW'(a[CO_P[i]]) * PW'(a[CO_Q[i]]);
                r_pb[i] <= PW'(a[CO_R[i]]) * PW'(a[CO_S[i]]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_col[0] <= a[0];
            r1_col[1] <= a[3];
            r1_col[2] <= a[6];
            r2_col    <= r1_col;
        end
    end

    // ---- stage 2: cofactors -------------------------------------------------
    logic signed [CW-1:0] r2_cof [9];
    logic signed [CW-1:0] r3_cof [9];
    logic signed [CW-1:0] r4_cof [9];

    for (genvar i = 0; i < 9; i++) begin : g_cof
        always_ff @(posedge i_clk) begin
            if (en) begin
                r2_cof[i] <= CW'(r_pa[i]) - CW'(r_pb[i]);
                r3_cof[i] <= r2_cof[i];
                r4_cof[i] <= r3_cof[i];
            end
        end
    end

    // ---- stage 3: determinant partial products, cofactor split in two -------
    logic signed [PW-1:0]  r_hi [3];
    logic signed [PW+1:0]  r_lo [3];

    for (genvar j = 0; j < 3; j++) begin : g_detp
        logic signed [W-1:0] chi;
        logic signed [W+1:0] clo;
        assign chi = r2_cof[j][CW-1:W+1];
        assign clo = $signed({1'b0, r2_cof[j][W:0]});
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_hi[j] <= PW'(r2_col[j]) * PW'(chi);
                r_lo[j] <= (PW+2)'(r2_col[j]) * clo;
            end
        end
    end

    // ---- stage 4: determinant ------------------------------------------------
    logic signed [DETW-1:0] term [3];
    logic signed [DETW-1:0] r_det;

    for (genvar j = 0; j < 3; j++) begin : g_term
        assign term[j] = (DETW'(r_hi[j]) <<< (W + 1)) + DETW'(r_lo[j]);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_det <= term[0] + term[1] + term[2];
        end
    end

    // ---- stage 5: magnitudes, signs, scaled numerators -----------------------
    logic [NW-1:0]   r_num [9];
    logic            r5_neg [9];
    logic [DETW-1:0] r_dmag;
    logic            r5_zero;

    logic [DETW-1:0] dmag;
    assign dmag = r_det[DETW-1] ? DETW'(-r_det) : DETW'(r_det);

    for (genvar i = 0; i < 9; i++) begin : g_num
        logic signed [CW:0] ce;
        logic [CW:0]        cm;
        assign ce = (CW+1)'(r4_cof[i]);
        assign cm = ce[CW] ? (CW+1)'(-ce) : (CW+1)'(ce);
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_num[i]  <= NW'(cm) << (2 * FRAC_BITS);
                r5_neg[i] <= r4_cof[i][CW-1] ^ r_det[DETW-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dmag  <= dmag;
            r5_zero <= (r_det == '0);
        end
    end

    // ---- divider stages -------------------------------------------------------
    logic [QB-1:0] q   [9];
    logic          ovf [9];

    for (genvar i = 0; i < 9; i++) begin : g_div
        mi3_div #(
            .NW  (NW),
            .DMW (DETW),
            .QB  (QB)
        ) u_div (
            .i_clk (i_clk),
            .i_en  (en),
            .i_num (r_num[i]),
            .i_den (r_dmag),
            .o_q   (q[i]),
            .o_ovf (ovf[i])
        );
    end

    // carry sign and singular flags alongside the divider
    logic [8:0] r_dneg  [DD];
    logic       r_dzero [DD];

    for (genvar k = 0; k < DD; k++) begin : g_side
        if (k == 0) begin : g_head
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_dneg[k]  <= {r5_neg[8], r5_neg[7], r5_neg[6], r5_neg[5],
                                   r5_neg[4], r5_neg[3], r5_neg[2], r5_neg[1],
                                   r5_neg[0]};
                    r_dzero[k] <= r5_zero;
                end
            end
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_dvld[k] <= 1'b0;
                end else if (en) begin
                    r_dvld[k] <= r_vld[4];
                end
            end
        end else begin : g_tail
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_dneg[k]  <= r_dneg[k-1];
                    r_dzero[k] <= r_dzero[k-1];
                end
            end
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_dvld[k] <= 1'b0;
                end else if (en) begin
                    r_dvld[k] <= r_dvld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[3:0], i_valid};
        end
    end

    // ---- output: saturate, apply sign ----------------------------------------
    localparam logic [QB-1:0] MAXP = {2'b00, {(W-1){1'b1}}};
    localparam logic [QB-1:0] MINM = MAXP + QB'(1);

    logic [W-1:0]  res [9];
    logic [W-1:0]  r_inv [9];
    logic          r_sing;
    logic          r_ovalid;

    for (genvar i = 0; i < 9; i++) begin : g_sat
        logic [QB-1:0] pv;
        logic [QB-1:0] nv;
        assign pv = (ovf[i] || q[i] > MAXP) ? MAXP : q[i];
        assign nv = (ovf[i] || q[i] > MINM) ? MINM : q[i];
        always_comb begin
            if (r_dzero[DD-1]) begin
                res[i] = '0;
            end else if (r_dneg[DD-1][i]) begin
                res[i] = W'(-nv);
            end else begin
                res[i] = W'(pv);
            end
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_inv[i] <= res[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sing <= r_dzero[DD-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (en) begin
            r_ovalid <= r_dvld[DD-1];
        end
    end

    assign o_valid         = r_ovalid;
    assign o_data.inv00    = FIELD_W'(r_inv[0]);
    assign o_data.inv01    = FIELD_W'(r_inv[1]);
    assign o_data.inv02    = FIELD_W'(r_inv[2]);
    assign o_data.inv10    = FIELD_W'(r_inv[3]);
    assign o_data.inv11    = FIELD_W'(r_inv[4]);
    assign o_data.inv12    = FIELD_W'(r_inv[5]);
    assign o_data.inv20    = FIELD_W'(r_inv[6]);
    assign o_data.inv21    = FIELD_W'(r_inv[7]);
    assign o_data.inv22    = FIELD_W'(r_inv[8]);
    assign o_data.singular = r_sing;

    // ---- assertions -----------------------------------------------------------
    // a singular result carries zero in the four corner and the centre entries of the inverse
    a_sing_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.singular |-> (r_inv[0] == '0) && (r_inv[4] == '0)
            && (r_inv[8] == '0) && (r_inv[2] == '0) && (r_inv[6] == '0))
        else $error("singular result with non-zero inverse");

    // a stall freezes the front stage valid bits and the last divider valid bit
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |=> $stable(r_vld) && $stable(r_dvld[DD-1]))
        else $error("pipeline moved during stall");

    // reset empties the pipeline
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && (r_vld == '0))
        else $error("pipeline not empty after reset");

endmodule
